// ----- hdl/irlp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irlp_pkg: shared types and constants of the integer range list parser
// Character codes, result kinds, parser phases and the result record.
// ----------------------------------------------------------------------------
package irlp_pkg;

    // Field widths fixed by the interface
    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 32;
    localparam int OCNT_W  = 16;
    localparam int KIND_W  = 2;

    // Default width of the internal saturating range counter
    localparam int COUNT_WIDTH_DEF = 16;

    // Result queue geometry
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Character codes
    localparam logic [CHAR_W-1:0] CHR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHR_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CHR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHR_SEMI  = 8'h3B;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_RANGE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

    // Saturation cap of the number magnitude (2^31)
    localparam logic [VALUE_W-1:0] MAG_CAP   = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;

    // Parser phases, one-hot
    typedef enum logic [10:0] {
        PH_START    = 11'b000_0000_0001,
        PH_WS_SPACE = 11'b000_0000_0010,
        PH_WS_MIXED = 11'b000_0000_0100,
        PH_SIGN1    = 11'b000_0000_1000,
        PH_DASH1    = 11'b000_0001_0000,
        PH_NUM1     = 11'b000_0010_0000,
        PH_SECOND   = 11'b000_0100_0000,
        PH_SIGN2    = 11'b000_1000_0000,
        PH_NUM2     = 11'b001_0000_0000,
        PH_TRAIL    = 11'b010_0000_0000,
        PH_DRAIN    = 11'b100_0000_0000
    } phase_t;

    // Parser state apart from the range counter
    typedef struct packed {
        phase_t              phase;
        logic [VALUE_W-1:0]  first_bound;
        logic [VALUE_W-1:0]  magnitude;
        logic                negative;
    } parse_state_t;

    // One result item
    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] range_low;
        logic signed [VALUE_W-1:0] range_high;
        logic [OCNT_W-1:0]         item_count;
        logic                      last;
    } result_t;

    // Results of one character: zero, one or two items
    typedef struct packed {
        logic [1:0] num;
        result_t    r0;
        result_t    r1;
    } step_out_t;

endpackage

// ----- hdl/irlp_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irlp_step: one character step of the range list parser
// Next parser state and the zero, one or two results caused by a character.
// ----------------------------------------------------------------------------
module irlp_step #(
    parameter int COUNT_WIDTH = irlp_pkg::COUNT_WIDTH_DEF
) (
    input  logic [irlp_pkg::CHAR_W-1:0] char_code,
    input  irlp_pkg::parse_state_t      st,
    input  logic [COUNT_WIDTH-1:0]      cnt,
    output irlp_pkg::parse_state_t      st_next,
    output logic [COUNT_WIDTH-1:0]      cnt_next,
    output irlp_pkg::step_out_t         res
);
    import irlp_pkg::*;

    localparam int EXT_W = COUNT_WIDTH + OCNT_W;

    // Counter as seen on the output port: zero-extended, then low bits
    function automatic logic [OCNT_W-1:0] cnt_out(input logic [COUNT_WIDTH-1:0] c);
        logic [EXT_W-1:0] ext;
        begin
            ext = {{OCNT_W{1'b0}}, c};
            return ext[OCNT_W-1:0];
        end
    endfunction

    logic                 is_ws;
    logic                 is_dig;
    logic                 is_sign;
    logic                 is_term;
    logic [3:0]           digit;
    logic [VALUE_W+3:0]   mag_x10;
    logic [VALUE_W-1:0]   mag_acc;
    logic [VALUE_W-1:0]   num_val;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic                 do_fail;
    logic                 do_list;
    logic                 do_item;
    logic [VALUE_W-1:0]   item_a;
    logic signed [VALUE_W-1:0] sa;
    logic signed [VALUE_W-1:0] sb;

    // Character classes
    assign is_ws   = (char_code == CHR_SPACE) ||
                     (char_code >= CHR_TAB && char_code <= CHR_CR);
    assign is_dig  = (char_code >= CHR_ZERO) && (char_code <= CHR_NINE);
    assign is_sign = (char_code == CHR_PLUS) || (char_code == CHR_DASH);
    assign is_term = (char_code == CHR_NUL) || (char_code == CHR_SPACE) ||
                     (char_code == CHR_SEMI);
    assign digit   = char_code[3:0];

    // Accumulate one decimal digit, saturating at 2^31
    assign mag_x10 = ({4'b0, st.magnitude} << 3) + ({4'b0, st.magnitude} << 1)
                     + {{(VALUE_W){1'b0}}, digit};
    assign mag_acc = (mag_x10 > {4'b0, MAG_CAP}) ? MAG_CAP : mag_x10[VALUE_W-1:0];

    // Signed value of the current number, clamped to the 32-bit range
    assign num_val = st.negative ? (~st.magnitude + 1'b1)
                   : (st.magnitude[VALUE_W-1] ? POS_LIMIT : st.magnitude);

    // Saturating range count
    assign cnt_inc = (&cnt) ? cnt : cnt + 1'b1;

    // Range bounds before ordering: first bound and current number
    assign sa = item_a;
    assign sb = num_val;

    always_comb begin
        st_next  = st;
        cnt_next = cnt;
        res      = '0;
        do_fail  = 1'b0;
        do_list  = 1'b0;
        do_item  = 1'b0;
        item_a   = num_val;

        // Phase transitions
        unique case (st.phase)
            PH_START: begin
                if (char_code == CHR_NUL) begin
                    do_list = 1'b1;
                end else if (char_code == CHR_SPACE) begin
                    st_next.phase = PH_WS_SPACE;
                end else if (is_ws) begin
                    st_next.phase = PH_WS_MIXED;
                end else if (char_code == CHR_PLUS) begin
                    st_next.negative = 1'b0;
                    st_next.phase    = PH_SIGN1;
                end else if (char_code == CHR_DASH) begin
                    st_next.phase = PH_DASH1;
                end else if (is_dig) begin
                    st_next.negative  = 1'b0;
                    st_next.magnitude = {{(VALUE_W-4){1'b0}}, digit};
                    st_next.phase     = PH_NUM1;
                end else begin
                    do_fail = 1'b1;
                end
            end
            PH_WS_SPACE, PH_WS_MIXED: begin
                if (char_code == CHR_NUL && st.phase == PH_WS_SPACE) begin
                    do_list = 1'b1;
                end else if (char_code == CHR_SPACE) begin
                    st_next.phase = st.phase;
                end else if (is_ws) begin
                    st_next.phase = PH_WS_MIXED;
                end else if (is_sign) begin
                    st_next.negative = (char_code == CHR_DASH);
                    st_next.phase    = PH_SIGN1;
                end else if (is_dig) begin
                    st_next.negative  = 1'b0;
                    st_next.magnitude = {{(VALUE_W-4){1'b0}}, digit};
                    st_next.phase     = PH_NUM1;
                end else begin
                    do_fail = 1'b1;
                end
            end
            PH_SIGN1, PH_SIGN2: begin
                if (is_dig) begin
                    st_next.magnitude = {{(VALUE_W-4){1'b0}}, digit};
                    st_next.phase     = (st.phase == PH_SIGN1) ? PH_NUM1 : PH_NUM2;
                end else begin
                    do_fail = 1'b1;
                end
            end
            PH_DASH1, PH_SECOND: begin
                // a lone dash opens a range that starts at zero
                if (is_dig && st.phase == PH_DASH1) begin
                    st_next.negative  = 1'b1;
                    st_next.magnitude = {{(VALUE_W-4){1'b0}}, digit};
                    st_next.phase     = PH_NUM1;
                end else begin
                    if (st.phase == PH_DASH1) begin
                        st_next.first_bound = '0;
                    end
                    if (is_ws) begin
                        st_next.phase = PH_SECOND;
                    end else if (is_sign) begin
                        st_next.negative = (char_code == CHR_DASH);
                        st_next.phase    = PH_SIGN2;
                    end else if (is_dig) begin
                        st_next.negative  = 1'b0;
                        st_next.magnitude = {{(VALUE_W-4){1'b0}}, digit};
                        st_next.phase     = PH_NUM2;
                    end else begin
                        do_fail = 1'b1;
                    end
                end
            end
            PH_NUM1: begin
                if (is_dig) begin
                    st_next.magnitude = mag_acc;
                end else if (char_code == CHR_DASH) begin
                    st_next.first_bound = num_val;
                    st_next.phase       = PH_SECOND;
                end else begin
                    do_item = 1'b1;
                end
            end
            PH_NUM2: begin
                if (is_dig) begin
                    st_next.magnitude = mag_acc;
                end else begin
                    item_a  = st.first_bound;
                    do_item = 1'b1;
                end
            end
            PH_TRAIL: begin
                if (char_code == CHR_SPACE) begin
                    st_next.phase = PH_TRAIL;
                end else if (char_code == CHR_NUL) begin
                    do_list = 1'b1;
                end else begin
                    do_fail = 1'b1;
                end
            end
            PH_DRAIN: begin
                // drop bytes until the end of the list
                if (char_code == CHR_NUL) begin
                    st_next  = '{phase: PH_START, first_bound: '0, magnitude: '0,
                                 negative: 1'b0};
                    cnt_next = '0;
                end
            end
            default: begin
                st_next = st;
            end
        endcase

        // Finished item: bad terminator turns into a format error
        if (do_item && !is_term) begin
            do_fail = 1'b1;
        end else if (do_item) begin
            cnt_next            = cnt_inc;
            res.r0.kind         = KIND_RANGE;
            res.r0.range_low    = (sa < sb) ? sa : sb;
            res.r0.range_high   = (sa < sb) ? sb : sa;
            res.r0.item_count   = cnt_out(cnt_inc);
            res.r0.last         = (char_code != CHR_NUL);
            if (char_code == CHR_NUL) begin
                res.num           = 2'd2;
                res.r1.kind       = KIND_DONE;
                res.r1.item_count = cnt_out(cnt_inc);
                res.r1.last       = 1'b1;
                st_next  = '{phase: PH_START, first_bound: '0, magnitude: '0,
                             negative: 1'b0};
                cnt_next = '0;
            end else begin
                res.num       = 2'd1;
                st_next.phase = (char_code == CHR_SPACE) ? PH_TRAIL : PH_START;
            end
        end

        // Format error
        if (do_fail) begin
            res.num           = 2'd1;
            res.r0            = '0;
            res.r0.kind       = KIND_ERROR;
            res.r0.item_count = cnt_out(cnt);
            res.r0.last       = 1'b1;
            cnt_next          = cnt;
            if (char_code == CHR_NUL) begin
                st_next  = '{phase: PH_START, first_bound: '0, magnitude: '0,
                             negative: 1'b0};
                cnt_next = '0;
            end else begin
                st_next       = st;
                st_next.phase = PH_DRAIN;
            end
        end

        // End of list
        if (do_list) begin
            res.num           = 2'd1;
            res.r0.kind       = KIND_DONE;
            res.r0.item_count = cnt_out(cnt);
            res.r0.last       = 1'b1;
            st_next  = '{phase: PH_START, first_bound: '0, magnitude: '0,
                         negative: 1'b0};
            cnt_next = '0;
        end
    end

endmodule

// ----- hdl/irlp_outq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irlp_outq: result queue of the range list parser
// Four-entry register queue; takes up to two items a cycle, gives one.
// ----------------------------------------------------------------------------
module irlp_outq (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  irlp_pkg::step_out_t               push,
    output logic [irlp_pkg::QCNT_W-1:0]       fill,
    output logic                              m_valid,
    input  logic                              m_ready,
    output irlp_pkg::result_t                 head
);
    import irlp_pkg::*;

    result_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg;
    logic [QCNT_W-1:0]   cnt_next;
    logic [QPTR_W-1:0]   wr_ptr_p1;
    logic                pop;

    assign m_valid   = (cnt_reg != '0);
    assign pop       = m_valid && m_ready;
    assign head      = mem_reg[rd_ptr_reg];
    assign fill      = cnt_reg;
    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg + push.num[QPTR_W-1:0];
        rd_ptr_next = rd_ptr_reg + {{(QPTR_W-1){1'b0}}, pop};
        cnt_next    = cnt_reg + {{(QCNT_W-2){1'b0}}, push.num}
                      - {{(QCNT_W-1){1'b0}}, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Item storage
    always_ff @(posedge aclk) begin
        if (push.num != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.num == 2'd2) begin
            mem_reg[wr_ptr_p1] <= push.r1;
        end
    end

endmodule

// ----- hdl/integer_range_list_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_range_list_parser: streaming parser of lists like "5;6;4-9;10"
// One character per item in, range / done / error results out.
//
//   channel   dir   payload                                        handshake
//   s_        in    char_code                                      s_valid/s_ready
//   m_        out   kind, range_low, range_high, item_count, last  m_valid/m_ready
//
// A character is registered on entry and parsed from that register; its
// results land in a four-entry queue, a register stage from which the
// output is driven. One character a cycle is sustained while the queue
// has two free entries. A character that ends an item with the 0 byte
// gives two results. Input stalls only while the queue has fewer than
// two free entries. Reset is synchronous and starts a new list.
// ----------------------------------------------------------------------------
module integer_range_list_parser #(
    parameter int COUNT_WIDTH = irlp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [irlp_pkg::CHAR_W-1:0]         s_char_code,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [irlp_pkg::KIND_W-1:0]         m_kind,
    output logic signed [irlp_pkg::VALUE_W-1:0] m_range_low,
    output logic signed [irlp_pkg::VALUE_W-1:0] m_range_high,
    output logic [irlp_pkg::OCNT_W-1:0]         m_item_count,
    output logic                                m_last
);
    import irlp_pkg::*;

    logic                   in_valid_reg;
    logic [CHAR_W-1:0]      in_char_reg;
    parse_state_t           state_reg;
    parse_state_t           state_next;
    logic [COUNT_WIDTH-1:0] ranges_reg;
    logic [COUNT_WIDTH-1:0] ranges_next;
    step_out_t              step_res;
    step_out_t              push;
    logic [QCNT_W-1:0]      q_fill;
    logic                   step_go;
    result_t                head;

    // Parse when a character is held and two queue entries are free
    assign step_go = in_valid_reg && (q_fill <= QCNT_W'(QDEPTH - 2));
    assign s_ready = !in_valid_reg || step_go;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_char_reg <= s_char_code;
        end
    end

    // Character step
    irlp_step #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_step (
        .char_code (in_char_reg),
        .st        (state_reg),
        .cnt       (ranges_reg),
        .st_next   (state_next),
        .cnt_next  (ranges_next),
        .res       (step_res)
    );

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= '{phase: PH_START, first_bound: '0, magnitude: '0,
                            negative: 1'b0};
            ranges_reg <= '0;
        end else if (step_go) begin
            state_reg  <= state_next;
            ranges_reg <= ranges_next;
        end
    end

    // Results go to the queue only when the step fires
    always_comb begin
        push = step_res;
        if (!step_go) begin
            push.num = 2'd0;
        end
    end

    irlp_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .fill    (q_fill),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .head    (head)
    );

    assign m_kind       = head.kind;
    assign m_range_low  = head.range_low;
    assign m_range_high = head.range_high;
    assign m_item_count = head.item_count;
    assign m_last       = head.last;

    // Queue never holds more than its depth
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_fill <= QCNT_W'(QDEPTH))
        else $error("result queue overfilled");

    // Bytes after an error give no result until the 0 byte
    a_drain_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        step_go && state_reg.phase == PH_DRAIN && in_char_reg != CHR_NUL
        |-> step_res.num == 2'd0)
        else $error("result given while draining");

    // A done result starts a new list with a cleared count
    a_done_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step_go && (step_res.num == 2'd2 ||
                    (step_res.num == 2'd1 && step_res.r0.kind == KIND_DONE))
        |=> ranges_reg == '0 && state_reg.phase == PH_START)
        else $error("count not cleared after end of list");

endmodule

// ----- bench/integer_range_list_parser_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_range_list_parser_tb: self-checking bench of the range list parser
// Streams characters of short range lists, a few hand-picked lists first and
// then random well-formed lists with random content mixed with corrupted
// lists and byte noise. A software copy of the parser predicts every range,
// done and error result; the results the block returns are compared field
// by field, in order. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module integer_range_list_parser_tb;

    import irlp_pkg::*;

    localparam int          RANDOM_CHARS = 1900;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          IDLE_PCT     = 9;
    localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the parser state and queues the results it predicts
    // ------------------------------------------------------------------------
    class range_list_board;
        phase_t             phase;
        logic [VALUE_W-1:0] first_bound;
        logic [VALUE_W-1:0] magnitude;
        logic               negative;
        logic [OCNT_W-1:0]  ranges_seen;
        result_t            expected_results[$];
        int                 errors;

        function new();
            restart();
            errors = 0;
        endfunction

        function void restart();
            phase       = PH_START;
            first_bound = '0;
            magnitude   = '0;
            negative    = 1'b0;
            ranges_seen = '0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function bit is_blank(logic [CHAR_W-1:0] c);
            return c == CHR_SPACE || (c >= CHR_TAB && c <= CHR_CR);
        endfunction

        function bit is_digit(logic [CHAR_W-1:0] c);
            return c >= CHR_ZERO && c <= CHR_NINE;
        endfunction

        function void push_result(logic [KIND_W-1:0] kind, longint lo, longint hi,
                                  logic last);
            result_t r;
            r.kind       = kind;
            r.range_low  = VALUE_W'(lo);
            r.range_high = VALUE_W'(hi);
            r.item_count = ranges_seen;
            r.last       = last;
            expected_results.push_back(r);
        endfunction

        // Error result; the rest of the list is dropped up to its 0 byte
        function void fail_on(logic [CHAR_W-1:0] c);
            push_result(KIND_ERROR, 0, 0, 1'b1);
            if (c == CHR_NUL)
                restart();
            else
                phase = PH_DRAIN;
        endfunction

        function void end_list();
            push_result(KIND_DONE, 0, 0, 1'b1);
            restart();
        endfunction

        function void start_number(logic neg, logic [CHAR_W-1:0] c);
            negative  = neg;
            magnitude = VALUE_W'(c - CHR_ZERO);
        endfunction

        // Magnitude saturates at 2^31
        function void add_digit(logic [CHAR_W-1:0] c);
            longint m;
            m = magnitude;
            m = m * 10 + longint'(c - CHR_ZERO);
            if (m > longint'(MAG_CAP))
                m = MAG_CAP;
            magnitude = VALUE_W'(m);
        endfunction

        function longint number_value();
            longint v;
            v = magnitude;
            if (negative)
                return -v;
            if (v > longint'(POS_LIMIT))
                v = POS_LIMIT;
            return v;
        endfunction

        // Item closed by c: only 0, space or ';' may close it
        function void finish_item(longint a, longint b, logic [CHAR_W-1:0] c);
            if (c != CHR_NUL && c != CHR_SPACE && c != CHR_SEMI) begin
                fail_on(c);
                return;
            end
            if (ranges_seen != COUNT_MAX)
                ranges_seen++;
            push_result(KIND_RANGE, (a < b) ? a : b, (a < b) ? b : a, c != CHR_NUL);
            if (c == CHR_NUL)
                end_list();
            else
                phase = (c == CHR_SPACE) ? PH_TRAIL : PH_START;
        endfunction

        // First character after the joining dash
        function void second_start(logic [CHAR_W-1:0] c);
            if (is_blank(c)) begin
                phase = PH_SECOND;
            end else if (c == CHR_PLUS || c == CHR_DASH) begin
                negative = (c == CHR_DASH);
                phase    = PH_SIGN2;
            end else if (is_digit(c)) begin
                start_number(1'b0, c);
                phase = PH_NUM2;
            end else begin
                fail_on(c);
            end
        endfunction

        // Accepted input item: advance the parser and queue its results
        function void take_char(logic [CHAR_W-1:0] c);
            longint fb;
            case (phase)
                PH_START: begin
                    if (c == CHR_NUL) begin
                        end_list();
                    end else if (c == CHR_SPACE) begin
                        phase = PH_WS_SPACE;
                    end else if (is_blank(c)) begin
                        phase = PH_WS_MIXED;
                    end else if (c == CHR_PLUS) begin
                        negative = 1'b0;
                        phase    = PH_SIGN1;
                    end else if (c == CHR_DASH) begin
                        phase = PH_DASH1;
                    end else if (is_digit(c)) begin
                        start_number(1'b0, c);
                        phase = PH_NUM1;
                    end else begin
                        fail_on(c);
                    end
                end
                PH_WS_SPACE, PH_WS_MIXED: begin
                    if (c == CHR_NUL && phase == PH_WS_SPACE) begin
                        end_list();
                    end else if (is_blank(c)) begin
                        if (c != CHR_SPACE)
                            phase = PH_WS_MIXED;
                    end else if (c == CHR_PLUS || c == CHR_DASH) begin
                        negative = (c == CHR_DASH);
                        phase    = PH_SIGN1;
                    end else if (is_digit(c)) begin
                        start_number(1'b0, c);
                        phase = PH_NUM1;
                    end else begin
                        fail_on(c);
                    end
                end
                PH_SIGN1: begin
                    if (is_digit(c)) begin
                        start_number(negative, c);
                        phase = PH_NUM1;
                    end else begin
                        fail_on(c);
                    end
                end
                PH_DASH1: begin
                    // a dash opening the item: negative number or range from 0
                    if (is_digit(c)) begin
                        start_number(1'b1, c);
                        phase = PH_NUM1;
                    end else begin
                        first_bound = '0;
                        second_start(c);
                    end
                end
                PH_NUM1: begin
                    if (is_digit(c)) begin
                        add_digit(c);
                    end else if (c == CHR_DASH) begin
                        first_bound = VALUE_W'(number_value());
                        phase       = PH_SECOND;
                    end else begin
                        finish_item(number_value(), number_value(), c);
                    end
                end
                PH_SECOND: second_start(c);
                PH_SIGN2: begin
                    if (is_digit(c)) begin
                        start_number(negative, c);
                        phase = PH_NUM2;
                    end else begin
                        fail_on(c);
                    end
                end
                PH_NUM2: begin
                    if (is_digit(c)) begin
                        add_digit(c);
                    end else begin
                        fb = $signed(first_bound);
                        finish_item(fb, number_value(), c);
                    end
                end
                PH_TRAIL: begin
                    if (c == CHR_NUL)
                        end_list();
                    else if (c != CHR_SPACE)
                        fail_on(c);
                end
                default: begin
                    // dropping bytes after an error
                    if (c == CHR_NUL)
                        restart();
                end
            endcase
        endfunction

        function void check_field(string name, logic signed [63:0] want,
                                  logic signed [63:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // Accepted result item against the oldest prediction
        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0) begin
                $error("unexpected result: kind %0d, item_count %0d",
                       got.kind, got.item_count);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            check_field("kind", want.kind, got.kind);
            check_field("range_low", $signed(want.range_low), $signed(got.range_low));
            check_field("range_high", $signed(want.range_high), $signed(got.range_high));
            check_field("item_count", want.item_count, got.item_count);
            check_field("last", want.last, got.last);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals, clock, block
    // ------------------------------------------------------------------------
    logic                       aclk;
    logic                       aresetn     = 1'b0;
    logic                       s_valid     = 1'b0;
    logic                       s_ready;
    logic [CHAR_W-1:0]          s_char_code = '0;
    logic                       m_valid;
    logic                       m_ready     = 1'b0;
    logic [KIND_W-1:0]          m_kind;
    logic signed [VALUE_W-1:0]  m_range_low;
    logic signed [VALUE_W-1:0]  m_range_high;
    logic [OCNT_W-1:0]          m_item_count;
    logic                       m_last;

    range_list_board board = new();
    logic [CHAR_W-1:0] list_text[$];
    int  chars_sent  = 0;
    int  cycle_count = 0;
    int  idle_pct    = IDLE_PCT;
    bit  paused_once = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    integer_range_list_parser DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_char_code  (s_char_code),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_range_low  (m_range_low),
        .m_range_high (m_range_high),
        .m_item_count (m_item_count),
        .m_last       (m_last)
    );

    // ------------------------------------------------------------------------
    // Result side: check accepted items, stall at random
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.kind       = m_kind;
            got.range_low  = m_range_low;
            got.range_high = m_range_high;
            got.item_count = m_item_count;
            got.last       = m_last;
            board.check_result(got);
        end
        m_ready <= ($urandom_range(99) >= idle_pct);
    end

    // ------------------------------------------------------------------------
    // Character side
    // ------------------------------------------------------------------------
    // valid stays high between back-to-back items; dropped only for a gap
    task automatic send_char(input logic [CHAR_W-1:0] c);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_char_code <= c;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        board.take_char(c);
        chars_sent++;
    endtask

    task automatic send_line(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
        send_char(CHR_NUL);
    endtask

    task automatic wait_drained();
        while (board.pending() != 0)
            @(posedge aclk);
    endtask

    function automatic logic [CHAR_W-1:0] blank_char();
        return ($urandom_range(4) == 0) ? CHAR_W'($urandom_range(9, 13)) : CHR_SPACE;
    endfunction

    // Mostly short numbers, now and then long enough to saturate
    function automatic void push_digits();
        int n;
        n = ($urandom_range(99) < 85) ? $urandom_range(1, 3) : $urandom_range(9, 12);
        repeat (n)
            list_text.push_back(CHR_ZERO + CHAR_W'($urandom_range(9)));
    endfunction

    function automatic void push_number();
        int s;
        if ($urandom_range(4) == 0)
            repeat ($urandom_range(1, 2)) list_text.push_back(blank_char());
        s = $urandom_range(5);
        if (s == 0)
            list_text.push_back(CHR_PLUS);
        else if (s == 1)
            list_text.push_back(CHR_DASH);
        push_digits();
    endfunction

    // One list up to its 0 byte: well-formed with random content, sometimes
    // corrupted, sometimes plain byte noise
    function automatic void build_list();
        int n_items;
        int tail;
        list_text.delete();
        if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(1, 12))
                list_text.push_back(CHAR_W'($urandom_range(255)));
            list_text.push_back(CHR_NUL);
            return;
        end
        n_items = $urandom_range(4);
        for (int i = 0; i < n_items; i++) begin
            if (i != 0)
                list_text.push_back(CHR_SEMI);
            case ($urandom_range(9))
                0: begin
                    // range from 0: dash, then a blank or a sign or a dash
                    list_text.push_back(CHR_DASH);
                    case ($urandom_range(2))
                        0:       list_text.push_back(blank_char());
                        1:       list_text.push_back(CHR_PLUS);
                        default: list_text.push_back(CHR_DASH);
                    endcase
                    push_digits();
                end
                1, 2, 3, 4: push_number();
                default: begin
                    push_number();
                    list_text.push_back(CHR_DASH);
                    push_number();
                end
            endcase
        end
        tail = $urandom_range(5);
        if (tail == 0)
            list_text.push_back(CHR_SEMI);
        if (tail <= 1)
            repeat ($urandom_range(1, 3)) list_text.push_back(CHR_SPACE);
        list_text.push_back(CHR_NUL);
        if ($urandom_range(99) < 12 && list_text.size() > 1)
            list_text[$urandom_range(list_text.size() - 2)] = CHAR_W'($urandom_range(1, 255));
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // empty list, blank list, empty item, tab then nothing
        send_line("");
        send_line(" ");
        send_line(";");
        send_line("\t");
        // reversed range with trailing space, range from 0, saturation
        send_line("9-3 ");
        send_line("-+7;");
        send_line("99999999999");

        while (chars_sent < RANDOM_CHARS) begin
            if (!paused_once && chars_sent >= RANDOM_CHARS / 2) begin
                paused_once = 1'b1;
                s_valid <= 1'b0;
                @(posedge aclk);
                wait_drained();
            end
            idle_pct = (chars_sent >= 400 && chars_sent < 800) ? 0 : IDLE_PCT;
            build_list();
            foreach (list_text[i])
                send_char(list_text[i]);
        end
        idle_pct = IDLE_PCT;
        s_valid <= 1'b0;
        @(posedge aclk);
        wait_drained();
        repeat (10) @(posedge aclk);

        if (board.errors == 0 && board.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Timeout
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

endmodule
